// File: rtl/anc_pkg.sv
`timescale 1ns / 1ps

package anc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;
  localparam int TTL_W   = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  // command codes
  localparam logic CMD_RESOLVE = 1'b0;
  localparam logic CMD_LEARN   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_ADDRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL_SECONDS     = 3'd3;

  localparam logic [IP_W-1:0]  BCAST_ADDR   = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [TTL_W-1:0] TTL_RESET    = 16'd60;

  typedef struct packed {
    logic [IP_W-1:0]    address;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [IP_W-1:0]  own_address;
    logic [IP_W-1:0]  gateway_address;
    logic [IP_W-1:0]  subnet_mask;
    logic [TTL_W-1:0] ttl_seconds;
  } cfg_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  hop;
    logic             request;
    logic             inactive;
  } result_t;

endpackage

// File: rtl/anc_ram.sv
`timescale 1ns / 1ps

module anc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/anc_engine.sv
`timescale 1ns / 1ps

module anc_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  anc_pkg::cfg_t              cfg_i,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd_i,
  input  logic [anc_pkg::IP_W-1:0]   address_i,
  input  logic [anc_pkg::MAC_W-1:0]  hw_addr_i,
  input  logic [anc_pkg::STAMP_W-1:0] now_i,
  output anc_pkg::ram_req_t          ram_req_o,
  input  anc_pkg::entry_t            ram_rdata_i,
  output anc_pkg::result_t           result_o
);

  import anc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t             state_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] wrtn_r;   // entry written since reset
  logic               issue_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               pend_r;
  logic [IDX_W-1:0]   pend_idx_r;

  logic               cmd_r;
  logic [IP_W-1:0]    key_r;
  logic [IP_W-1:0]    hop_r;
  logic [MAC_W-1:0]   mac_r;
  logic [STAMP_W-1:0] now_r;
  logic [IDX_W-1:0]   slot_r;

  logic [IDX_W-1:0]   vic_r, vic_nxt;
  logic [STAMP_W-1:0] vic_stamp_r, vic_stamp_nxt;
  logic               vic_done_r, vic_done_nxt;

  result_t            res_r;

  entry_t             rd_ent;
  logic               ent_live, expired, alive, match, last;
  logic [STAMP_W-1:0] age;
  logic [IP_W-1:0]    hop_c;

  // never-written entries read as zero
  assign rd_ent   = wrtn_r[pend_idx_r] ? ram_rdata_i : '0;
  assign ent_live = valid_r[pend_idx_r];
  assign age      = now_r - rd_ent.stamp;
  assign expired  = ent_live && (age > STAMP_W'(cfg_i.ttl_seconds));
  assign alive    = ent_live && !expired;
  assign match    = alive && (rd_ent.address == key_r);
  assign last     = (pend_idx_r == LAST_IDX);

  assign hop_c = ((cfg_i.subnet_mask & address_i) == (cfg_i.subnet_mask & cfg_i.own_address))
                 ? address_i : cfg_i.gateway_address;

  // victim: slot 0 seeds, first dead slot wins, else oldest stamp
  always_comb begin
    vic_nxt       = vic_r;
    vic_stamp_nxt = vic_stamp_r;
    vic_done_nxt  = vic_done_r;
    if (pend_idx_r == '0) begin
      vic_nxt       = '0;
      vic_stamp_nxt = rd_ent.stamp;
      vic_done_nxt  = 1'b0;
    end else if (!vic_done_r) begin
      if (!alive) begin
        vic_nxt      = pend_idx_r;
        vic_done_nxt = 1'b1;
      end else if (rd_ent.stamp < vic_stamp_r) begin
        vic_nxt       = pend_idx_r;
        vic_stamp_nxt = rd_ent.stamp;
      end
    end
  end

  always_comb begin
    ram_req_o.re    = (state_r == ST_SCAN) && issue_r;
    ram_req_o.raddr = rd_idx_r;
    ram_req_o.we    = (state_r == ST_WRITE);
    ram_req_o.waddr = slot_r;
    ram_req_o.wdata = '{address: key_r, mac: mac_r, stamp: now_r};
  end

  assign busy     = (state_r != ST_IDLE);
  assign result_o = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      wrtn_r      <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd_r    <= cmd_i;
            mac_r    <= hw_addr_i;
            now_r    <= now_i;
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            res_r    <= '0;
            if (cmd_i == CMD_LEARN) begin
              key_r   <= address_i;
              issue_r <= 1'b1;
              state_r <= ST_SCAN;
            end else if (cfg_i.own_address == '0) begin
              res_r.valid    <= 1'b1;
              res_r.inactive <= 1'b1;
            end else if (address_i == BCAST_ADDR) begin
              res_r.valid <= 1'b1;
              res_r.found <= 1'b1;
              res_r.mac   <= MAC_ALL_ONES;
              res_r.hop   <= hop_c;
            end else begin
              key_r   <= hop_c;
              hop_r   <= hop_c;
              issue_r <= 1'b1;
              state_r <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          // one read per cycle, data seen in the next cycle
          if (issue_r) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            if (rd_idx_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end
          end
          pend_r     <= issue_r;
          pend_idx_r <= rd_idx_r;

          if (pend_r) begin
            if (expired) begin
              valid_r[pend_idx_r] <= 1'b0;
            end
            vic_r       <= vic_nxt;
            vic_stamp_r <= vic_stamp_nxt;
            vic_done_r  <= vic_done_nxt;

            if (match || last) begin
              issue_r <= 1'b0;
              pend_r  <= 1'b0;
              if (cmd_r == CMD_LEARN) begin
                slot_r  <= match ? pend_idx_r : vic_nxt;
                state_r <= ST_WRITE;
              end else begin
                res_r.valid   <= 1'b1;
                res_r.found   <= match;
                res_r.mac     <= match ? rd_ent.mac : '0;
                res_r.hop     <= hop_r;
                res_r.request <= !match;
                state_r       <= ST_IDLE;
              end
            end
          end
        end

        ST_WRITE: begin
          valid_r[slot_r] <= 1'b1;
          wrtn_r[slot_r]  <= 1'b1;
          res_r.valid     <= 1'b1;
          state_r         <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/arp_neighbor_cache.sv
`timescale 1ns / 1ps

// ARP neighbor cache: ENTRIES IPv4-to-MAC entries with expiry and LRU-style
// replacement.
//
// Input: a command transfer is taken at a clock edge with start high and busy
// low. in_cmd selects resolve (next hop lookup) or learn (refresh or insert).
// Output: one result per command, shown for exactly one cycle with out_valid
// high. The receiver cannot stall; results must be captured on the strobe.
// Config: cfg_we/cfg_index/cfg_wdata write own address, gateway, subnet mask
// and TTL; write only while busy is low and no result is pending.
//
// Timing: inactive and broadcast resolves return in the cycle after transfer.
// A lookup reads one entry per cycle from the single RAM read port and stops
// at the first live match or the last entry; a resolve then returns, a learn
// first writes the entry back (ST_WRITE). busy drops in the cycle the result
// appears, so a new command can be taken while out_valid is high.
// Reset: synchronous, active low; clears every valid bit at once (no sweep),
// and loads the register reset values (TTL 60 s, addresses zero).

module arp_neighbor_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [anc_pkg::IP_W-1:0]      in_address,
  input  logic [anc_pkg::MAC_W-1:0]     in_hw_addr,
  input  logic [anc_pkg::STAMP_W-1:0]   in_now_seconds,
  // result channel
  output logic                          out_valid,
  output logic                          out_found,
  output logic [anc_pkg::MAC_W-1:0]     out_resolved_mac,
  output logic [anc_pkg::IP_W-1:0]      out_next_hop,
  output logic                          out_request_needed,
  output logic                          out_inactive,
  // configuration
  input  logic                          cfg_we,
  input  logic [anc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [anc_pkg::CFG_W-1:0]     cfg_wdata
);

  import anc_pkg::*;

  cfg_t              cfg_r;
  ram_req_t          ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  result_t           res;

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address     <= '0;
      cfg_r.gateway_address <= '0;
      cfg_r.subnet_mask     <= '0;
      cfg_r.ttl_seconds     <= TTL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:     cfg_r.own_address     <= cfg_wdata[IP_W-1:0];
        CFG_GATEWAY_ADDRESS: cfg_r.gateway_address <= cfg_wdata[IP_W-1:0];
        CFG_SUBNET_MASK:     cfg_r.subnet_mask     <= cfg_wdata[IP_W-1:0];
        CFG_TTL_SECONDS:     cfg_r.ttl_seconds     <= cfg_wdata[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  // entry store: address, MAC and stamp per slot
  anc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // scan, expiry, victim choice and write-back
  anc_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .start       (start),
    .busy        (busy),
    .cmd_i       (in_cmd),
    .address_i   (in_address),
    .hw_addr_i   (in_hw_addr),
    .now_i       (in_now_seconds),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .result_o    (res)
  );

  assign out_valid          = res.valid;
  assign out_found          = res.found;
  assign out_resolved_mac   = res.mac;
  assign out_next_hop       = res.hop;
  assign out_request_needed = res.request;
  assign out_inactive       = res.inactive;

endmodule

// File: rtl/anc_checker.sv
`timescale 1ns / 1ps

module anc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_cmd,
  input logic                          out_valid,
  input logic                          out_found,
  input logic [anc_pkg::MAC_W-1:0]     out_resolved_mac,
  input logic [anc_pkg::IP_W-1:0]      out_next_hop,
  input logic                          out_request_needed,
  input logic                          out_inactive
);

  import anc_pkg::*;

  // a hit and a miss never come together
  a_found_xor_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_request_needed))
    else $error("found and request_needed both set");

  // refused resolve carries nothing else
  a_inactive_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inactive) |->
      (!out_found && !out_request_needed && out_resolved_mac == '0 && out_next_hop == '0))
    else $error("inactive result with payload");

  // a miss reports no MAC
  a_miss_no_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_request_needed) |-> (out_resolved_mac == '0))
    else $error("miss with nonzero MAC");

  // learn always scans the table
  a_learn_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LEARN) |=> (busy && !out_valid))
    else $error("learn did not start a scan");

  // reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

endmodule

bind arp_neighbor_cache anc_checker u_anc_checker (.*);

// File: test/tb_arp_neighbor_cache.sv
`timescale 1ns / 1ps

module tb_arp_neighbor_cache;
  import anc_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int POOL_HOSTS  = 24;  // more hosts than entries, so victims get picked

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_t;

  // One queued driver step: a command transfer, a register write, or a
  // pause until every pending reply has come back.
  typedef struct {
    step_kind_t           kind;
    logic                 cmd;
    logic [IP_W-1:0]      addr;
    logic [MAC_W-1:0]     mac;
    logic [STAMP_W-1:0]   now;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    int                   gap_pct;
  } cache_step_t;

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  hop;
    logic             request;
    logic             inactive;
  } cache_reply_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 start          = 1'b0;
  logic                 busy;
  logic                 in_cmd         = CMD_RESOLVE;
  logic [IP_W-1:0]      in_address     = '0;
  logic [MAC_W-1:0]     in_hw_addr     = '0;
  logic [STAMP_W-1:0]   in_now_seconds = '0;
  logic                 out_valid;
  logic                 out_found;
  logic [MAC_W-1:0]     out_resolved_mac;
  logic [IP_W-1:0]      out_next_hop;
  logic                 out_request_needed;
  logic                 out_inactive;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;

  arp_neighbor_cache u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_address         (in_address),
    .in_hw_addr         (in_hw_addr),
    .in_now_seconds     (in_now_seconds),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_resolved_mac   (out_resolved_mac),
    .out_next_hop       (out_next_hop),
    .out_request_needed (out_request_needed),
    .out_inactive       (out_inactive),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  cache_step_t  pending_steps[$];
  cache_reply_t replies_due[$];
  logic         took_item = 1'b0;  // a command transfer happened at the last rising edge
  int           errors    = 0;
  int           cycle_count = 0;

  // Shadow of the neighbor table and registers.
  logic                 tab_valid [ENTRIES];
  logic [IP_W-1:0]      tab_addr  [ENTRIES];
  logic [MAC_W-1:0]     tab_mac   [ENTRIES];
  logic [STAMP_W-1:0]   tab_stamp [ENTRIES];
  logic [IP_W-1:0]      reg_own;
  logic [IP_W-1:0]      reg_gw;
  logic [IP_W-1:0]      reg_mask;
  logic [TTL_W-1:0]     reg_ttl;

  // Generator-side view of the settings, used to aim addresses and times.
  logic [IP_W-1:0]      gen_own  = '0;
  logic [IP_W-1:0]      gen_gw   = '0;
  logic [IP_W-1:0]      gen_mask = '0;
  int unsigned          gen_ttl  = TTL_RESET;
  logic [STAMP_W-1:0]   gen_clock = '0;
  int                   gen_gap  = 11;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Walk the table for target, dropping every expired entry passed on the
  // way; stops at the first live match. Age wraps at 32 bits.
  function automatic int scan_for(input logic [IP_W-1:0] target,
                                  input logic [STAMP_W-1:0] now);
    int              hit;
    logic [STAMP_W-1:0] age;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tab_valid[i]) begin
        age = now - tab_stamp[i];
        if (age > STAMP_W'(reg_ttl)) tab_valid[i] = 1'b0;
        else if (tab_addr[i] == target) hit = i;
      end
    end
    return hit;
  endfunction

  // Reply for one command, updating the shadow table as the block would.
  function automatic cache_reply_t cache_reply(input logic cmd,
                                               input logic [IP_W-1:0] addr,
                                               input logic [MAC_W-1:0] mac,
                                               input logic [STAMP_W-1:0] now);
    cache_reply_t    r;
    logic [IP_W-1:0] hop;
    int              slot;
    logic            picked;
    r = '0;
    if (cmd == CMD_LEARN) begin
      slot = scan_for(addr, now);
      if (slot < 0) begin
        // victim: first free slot from 1 up, else oldest stamp; slot 0 is
        // only the starting candidate and never tested for validity
        slot   = 0;
        picked = 1'b0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (!picked) begin
            if (!tab_valid[i]) begin
              slot   = i;
              picked = 1'b1;
            end else if (tab_stamp[i] < tab_stamp[slot]) begin
              slot = i;
            end
          end
        end
        tab_addr[slot] = addr;
      end
      tab_mac[slot]   = mac;
      tab_stamp[slot] = now;
      tab_valid[slot] = 1'b1;
    end else if (reg_own == '0) begin
      r.inactive = 1'b1;
    end else begin
      hop   = ((reg_mask & addr) == (reg_mask & reg_own)) ? addr : reg_gw;
      r.hop = hop;
      if (addr == BCAST_ADDR) begin
        // broadcast never touches the table
        r.found = 1'b1;
        r.mac   = MAC_ALL_ONES;
      end else begin
        slot = scan_for(hop, now);
        if (slot >= 0) begin
          r.found = 1'b1;
          r.mac   = tab_mac[slot];
        end else begin
          r.request = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Driver: everything changes on the falling edge. start is computed once
  // per step so back-to-back transfers keep it high without a glitch.
  always @(negedge clk) begin : drive
    cache_step_t step;
    logic        go;
    logic        write_now;
    go        = start;
    write_now = 1'b0;
    if (rst_n) begin
      if (start && took_item) go = 1'b0;
      if (!go && pending_steps.size() > 0) begin
        step = pending_steps[0];
        case (step.kind)
          STEP_ITEM: begin
            if ($urandom_range(99) >= step.gap_pct) begin
              void'(pending_steps.pop_front());
              go             = 1'b1;
              in_cmd         <= step.cmd;
              in_address     <= step.addr;
              in_hw_addr     <= step.mac;
              in_now_seconds <= step.now;
            end
          end
          STEP_CFG: begin
            // registers change only with the block idle
            if (replies_due.size() == 0 && !busy) begin
              void'(pending_steps.pop_front());
              write_now = 1'b1;
              cfg_index <= step.idx;
              cfg_wdata <= step.data;
            end
          end
          STEP_DRAIN: begin
            if (replies_due.size() == 0 && !busy) void'(pending_steps.pop_front());
          end
          default: void'(pending_steps.pop_front());
        endcase
      end
    end
    start  <= go;
    cfg_we <= write_now;
  end

  // Monitor and predictor: sample on the rising edge. A reply is checked
  // before the prediction for a transfer taken at the same edge.
  always @(posedge clk) begin : observe
    cache_reply_t got;
    cache_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tab_valid[i] = 1'b0;
        tab_addr[i]  = '0;
        tab_mac[i]   = '0;
        tab_stamp[i] = '0;
      end
      reg_own   = '0;
      reg_gw    = '0;
      reg_mask  = '0;
      reg_ttl   = TTL_RESET;
      took_item <= 1'b0;
    end else begin
      if (out_valid) begin
        got = '{out_found, out_resolved_mac, out_next_hop, out_request_needed, out_inactive};
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("reply with nothing pending, hop %h", got.hop));
        end else begin
          want = replies_due.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
          if (got.mac !== want.mac)
            report_mismatch($sformatf("resolved_mac %h, want %h", got.mac, want.mac));
          if (got.hop !== want.hop)
            report_mismatch($sformatf("next_hop %h, want %h", got.hop, want.hop));
          if (got.request !== want.request)
            report_mismatch($sformatf("request_needed %b, want %b",
                                      got.request, want.request));
          if (got.inactive !== want.inactive)
            report_mismatch($sformatf("inactive %b, want %b", got.inactive, want.inactive));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDRESS:     reg_own  = cfg_wdata[IP_W-1:0];
          CFG_GATEWAY_ADDRESS: reg_gw   = cfg_wdata[IP_W-1:0];
          CFG_SUBNET_MASK:     reg_mask = cfg_wdata[IP_W-1:0];
          CFG_TTL_SECONDS:     reg_ttl  = cfg_wdata[TTL_W-1:0];
          default: ;  // unknown index: write dropped
        endcase
      end
      if (start && !busy)
        replies_due.push_back(cache_reply(in_cmd, in_address, in_hw_addr, in_now_seconds));
      took_item <= start && !busy;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_arp_neighbor_cache NOT OK");
      $finish;
    end
  end

  task automatic add_item(input logic cmd, input logic [IP_W-1:0] addr,
                          input logic [MAC_W-1:0] mac, input logic [STAMP_W-1:0] now);
    cache_step_t s;
    s.kind = STEP_ITEM;  s.cmd = cmd;  s.addr = addr;  s.mac = mac;  s.now = now;
    s.idx  = '0;  s.data = '0;  s.gap_pct = gen_gap;
    pending_steps.push_back(s);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cache_step_t s;
    s.kind = STEP_CFG;  s.cmd = CMD_RESOLVE;  s.addr = '0;  s.mac = '0;  s.now = '0;
    s.idx  = idx;  s.data = data;  s.gap_pct = 0;
    pending_steps.push_back(s);
  endtask

  task automatic add_drain();
    cache_step_t s;
    s.kind = STEP_DRAIN;  s.cmd = CMD_RESOLVE;  s.addr = '0;  s.mac = '0;  s.now = '0;
    s.idx  = '0;  s.data = '0;  s.gap_pct = 0;
    pending_steps.push_back(s);
  endtask

  // All four registers; junk rides in the unused upper half of the TTL write.
  task automatic set_regs(input logic [IP_W-1:0] own, input logic [IP_W-1:0] gw,
                          input logic [IP_W-1:0] mask, input int unsigned ttl);
    gen_own  = own;
    gen_gw   = gw;
    gen_mask = mask;
    gen_ttl  = ttl;
    add_cfg(CFG_OWN_ADDRESS, own);
    add_cfg(CFG_GATEWAY_ADDRESS, gw);
    add_cfg(CFG_SUBNET_MASK, mask);
    add_cfg(CFG_TTL_SECONDS, CFG_W'({$urandom(), TTL_W'(ttl)}));
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  // A host on the current subnet, drawn from a small pool so that lookups hit.
  function automatic logic [IP_W-1:0] pool_addr();
    return (gen_own & gen_mask) | (IP_W'($urandom_range(1, POOL_HOSTS)) & ~gen_mask);
  endfunction

  // Time mostly creeps forward inside the TTL, sometimes jumps past it,
  // now and then leaps anywhere or steps back a little.
  task automatic advance_clock();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)      gen_clock += $urandom_range(0, (gen_ttl >> 3) + 1);
    else if (pick < 90) gen_clock += $urandom_range(0, gen_ttl + 1);
    else if (pick < 96) gen_clock += $urandom();
    else                gen_clock -= $urandom_range(0, 5);
  endtask

  initial begin : stimulus
    logic [IP_W-1:0] own;
    logic [IP_W-1:0] gw;
    logic [IP_W-1:0] mask;
    logic [IP_W-1:0] addr;
    int unsigned     ttl;
    int unsigned     pick;
    int unsigned     sel;

    // ---- directed part ----
    // registers still at reset: own address zero, resolves are refused
    add_item(CMD_RESOLVE, 32'h0A00_0005, random_mac(), 32'd0);
    add_item(CMD_RESOLVE, BCAST_ADDR, random_mac(), 32'd0);
    add_item(CMD_LEARN, 32'h0A00_0005, '0, 32'd0);  // learning still works

    set_regs(32'h0A00_0001, 32'h0A00_00FE, 32'hFFFF_FF00, TTL_RESET);
    add_cfg(CFG_IDX_W'(CFG_TTL_SECONDS + 1 + $urandom_range(0, 3)), $urandom());

    add_item(CMD_RESOLVE, 32'h0A00_0005, random_mac(), 32'd10);  // hit, MAC zero
    add_item(CMD_LEARN, 32'h0A00_0006, MAC_ALL_ONES, 32'd20);
    add_item(CMD_RESOLVE, 32'h0A00_0006, random_mac(), 32'd20);
    add_item(CMD_RESOLVE, BCAST_ADDR, random_mac(), 32'd21);     // broadcast, off subnet
    add_item(CMD_RESOLVE, 32'h0808_0808, random_mac(), 32'd22);  // gateway unknown: miss
    add_item(CMD_LEARN, 32'h0A00_00FE, random_mac(), 32'd23);
    add_item(CMD_RESOLVE, 32'h0808_0808, random_mac(), 32'd24);  // via gateway: hit
    add_item(CMD_RESOLVE, 32'h0A00_0005, random_mac(), 32'd60);  // age equals TTL: live
    add_item(CMD_RESOLVE, 32'h0A00_0005, random_mac(), 32'd61);  // one past TTL: expired
    add_item(CMD_LEARN, 32'h0A00_0006, random_mac(), 32'd62);    // refresh in place
    add_item(CMD_LEARN, 32'h0000_0000, random_mac(), 32'hFFFF_FFF0);
    add_item(CMD_LEARN, 32'h0A00_0007, random_mac(), 32'h0000_0010);  // across the wrap
    add_item(CMD_RESOLVE, 32'h0A00_0007, random_mac(), 32'h0000_0010);
    add_item(CMD_LEARN, BCAST_ADDR, random_mac(), 32'h0000_0011);
    add_item(CMD_RESOLVE, BCAST_ADDR, random_mac(), 32'h0000_0012);   // table bypassed
    add_item(CMD_RESOLVE, 32'h0A00_0009, random_mac(), 32'h0000_0012);

    // shortest lifetime, and a zero mask puts everything on the subnet
    set_regs(32'h0A00_0001, 32'h0000_0000, 32'h0000_0000, 1);
    add_item(CMD_LEARN, 32'h0A00_000A, random_mac(), 32'h0000_0020);
    add_item(CMD_RESOLVE, 32'h0A00_000A, random_mac(), 32'h0000_0021);
    add_item(CMD_RESOLVE, 32'h0A00_000A, random_mac(), 32'h0000_0022);
    add_item(CMD_RESOLVE, 32'h0000_0000, random_mac(), 32'h0000_0022);
    gen_clock = 32'h0000_0022;

    // ---- random part: ten settings, sender gaps 11%, then 58%, then none ----
    for (int p = 0; p < 10; p++) begin
      gen_gap = (p < 4) ? 11 : (p < 7) ? 58 : 0;
      own = (p == 5) ? BCAST_ADDR : IP_W'($urandom_range(1, 32'hFFFF_FFFF));
      case (p)
        0, 8:    mask = 32'h0000_0000;
        1:       mask = 32'hFFFF_FFFF;
        4:       mask = 32'hFFFF_0000;
        3, 6, 9: mask = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
        default: mask = 32'hFFFF_FF00;
      endcase
      case (p)
        0, 8:    ttl = 65535;
        1, 7:    ttl = 1;
        2:       ttl = TTL_RESET;
        4:       ttl = $urandom_range(1, 65535);
        5:       ttl = 5;
        6:       ttl = 300;
        default: ttl = $urandom_range(2, 300);
      endcase
      case (p % 4)
        3:       gw = '0;
        1:       gw = $urandom();
        default: gw = (own & mask) | (IP_W'(200) & ~mask);
      endcase
      set_regs(own, gw, mask, ttl);
      if (p == 4) add_cfg(CFG_IDX_W'(CFG_TTL_SECONDS + 1 + $urandom_range(0, 3)), $urandom());
      if (p % 3 == 1) gen_clock = 32'hFFFF_FFFF - $urandom_range(0, ttl);  // run into the wrap

      for (int n = 0; n < 48; n++) begin
        // hold off until the block has returned everything
        if (n == 24 && (p == 2 || p == 6)) add_drain();
        advance_clock();
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (pick < 45) begin
          addr = (sel < 75) ? pool_addr() : (sel < 85) ? gen_gw : IP_W'($urandom());
          add_item(CMD_LEARN, addr, random_mac(), gen_clock);
        end else begin
          if (sel < 55)      addr = pool_addr();
          else if (sel < 70) addr = $urandom();   // usually off subnet
          else if (sel < 80) addr = BCAST_ADDR;
          else if (sel < 90) addr = gen_gw;
          else               addr = gen_own;
          add_item(CMD_RESOLVE, addr, random_mac(), gen_clock);
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_steps.size() > 0 || replies_due.size() > 0 || start) @(posedge clk);
    // a stray reply would show within one full learn
    repeat (ENTRIES + 4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_arp_neighbor_cache OK");
    end else begin
      $display("tb_arp_neighbor_cache NOT OK");
    end
    $finish;
  end

endmodule
